// ----- rtl/double_ended_priority_queue_assert.svh -----
// Assertion macros shared by the checker of the double-ended priority queue.
// Expects signals named clock and reset in the scope where the macros are used.
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DPQ_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/dpq_pkg.sv -----
// Types and constants of the double-ended priority queue.
// No dependencies; used by every module of the block but dpq_or_tree.
package dpq_pkg;

   localparam int CLIENT_W = 20;
   localparam int PRIO_W = 32;
   localparam int DEFAULT_CAPACITY = 1024;

   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_POP_MAX = 2'd1,
      OP_POP_MIN = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_DUP   = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_INSERT,
      CMD_POP_MAX,
      CMD_POP_MIN
   } cell_cmd_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_APPLY
   } state_type;

   typedef struct packed {
      op_type                    op;
      logic [CLIENT_W-1:0]       client;
      logic signed [PRIO_W-1:0]  priority_req;
   } req_type;

   typedef struct packed {
      logic [CLIENT_W-1:0] client_out;
      status_type          status;
   } rsp_type;

   typedef struct packed {
      logic [CLIENT_W-1:0]       client;
      logic signed [PRIO_W-1:0]  key;
   } entry_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      cell_cmd_type              cmd;
      logic [CLIENT_W-1:0]       client;
      logic signed [PRIO_W-1:0]  key;
   } cell_ctl_type;

   // What each cell feeds into the reduction tree.
   typedef struct packed {
      logic                dup;
      logic [CLIENT_W-1:0] client;
   } leaf_type;

   localparam int LEAF_W = $bits(leaf_type);

endpackage

// ----- rtl/dpq_cell.sv -----
// One storage cell of the sorted chain: holds an entry and its valid bit.
// Depends on dpq_pkg.
module dpq_cell
   import dpq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctl_type  ctl,
   input  logic          left_valid,
   input  logic          left_ge,
   input  entry_type     left_entry,
   input  logic          right_valid,
   input  entry_type     right_entry,
   output logic          valid,
   output logic          ge,
   output entry_type     entry,
   output leaf_type      leaf
);

   entry_type entry_ff, entry_in;
   logic      valid_ff, valid_in;

   // A cell is at or past the insertion point when it is empty or holds a larger key.
   assign ge    = !valid_ff || (entry_ff.key > ctl.key);
   assign valid = valid_ff;
   assign entry = entry_ff;

   // The top entry is the last valid cell of the chain.
   assign leaf.dup    = valid_ff && (entry_ff.key == ctl.key);
   assign leaf.client = (valid_ff && !right_valid) ? entry_ff.client : '0;

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      case (ctl.cmd)
         CMD_INSERT: begin
            if (ge) begin
               if (left_ge) begin
                  entry_in = left_entry;
                  valid_in = left_valid;
               end else begin
                  entry_in.client = ctl.client;
                  entry_in.key    = ctl.key;
                  valid_in        = 1'b1;
               end
            end
         end
         CMD_POP_MIN: begin
            entry_in = right_entry;
            valid_in = right_valid;
         end
         CMD_POP_MAX: begin
            valid_in = valid_ff && right_valid;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ----- rtl/dpq_or_tree.sv -----
// Pipelined OR reduction over all cells, four inputs per node and a register
// per level. Has no dependencies; the including design sets the width.
module dpq_or_tree #(
   parameter int N = 4,
   parameter int W = 1
) (
   input  logic         clock,
   input  logic [W-1:0] leaves [N],
   output logic [W-1:0] root
);

   localparam int LEVELS = ($clog2(N) + 1) / 2;
   localparam int NP = 1 << (2 * LEVELS);
   localparam int NODES = (NP - 1) / 3;

   function automatic int lvl_off(input int lv);
      int off;
      off = 0;
      for (int j = 1; j < lv; j++) begin
         off += NP >> (2 * j);
      end
      return off;
   endfunction

   logic [W-1:0] leaf_pad [NP];
   logic [W-1:0] node_in  [NODES];
   logic [W-1:0] node_ff  [NODES];

   for (genvar k = 0; k < NP; k++) begin : g_pad
      if (k < N) begin : g_used
         assign leaf_pad[k] = leaves[k];
      end else begin : g_zero
         assign leaf_pad[k] = '0;
      end
   end

   for (genvar lv = 1; lv <= LEVELS; lv++) begin : g_lvl
      localparam int CNT = NP >> (2 * lv);
      localparam int OFF = lvl_off(lv);
      localparam int PREV = lvl_off(lv - 1);
      for (genvar n = 0; n < CNT; n++) begin : g_node
         if (lv == 1) begin : g_first
            assign node_in[OFF+n] = leaf_pad[4*n] | leaf_pad[4*n+1]
                                  | leaf_pad[4*n+2] | leaf_pad[4*n+3];
         end else begin : g_upper
            assign node_in[OFF+n] = node_ff[PREV+4*n] | node_ff[PREV+4*n+1]
                                  | node_ff[PREV+4*n+2] | node_ff[PREV+4*n+3];
         end
      end
   end

   always_ff @(posedge clock) begin
      node_ff <= node_in;
   end

   assign root = node_ff[NODES-1];

endmodule

// ----- rtl/double_ended_priority_queue.sv -----
// Double-ended priority queue built as a sorted chain of CAPACITY cells.
// A request is accepted in S_IDLE, waits in S_SCAN for the result of the
// LEVELS = ceil(log4(CAPACITY)) deep registered duplicate and top-entry
// reduction tree and is applied in S_APPLY, which registers the response;
// one request at a time, the next accepted once the last has left S_APPLY, which waits while a response is stalled.
// Reset empties the queue at once through the cell valid bits.
module double_ended_priority_queue
   import dpq_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   localparam int COUNT_W = $clog2(CAPACITY + 1);
   localparam int LEVELS = ($clog2(CAPACITY) + 1) / 2;
   localparam int WAIT_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

   state_type            state_ff, state_in;
   req_type              req_ff, req_in;
   logic [WAIT_W-1:0]    wait_ff, wait_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   cell_ctl_type         ctl;
   logic                 cell_valid [CAPACITY];
   logic                 cell_ge    [CAPACITY];
   entry_type            cell_entry [CAPACITY];
   leaf_type             cell_leaf  [CAPACITY];
   logic [LEAF_W-1:0]    leaf_bits  [CAPACITY];
   logic [LEAF_W-1:0]    root_bits;
   leaf_type             root;

   logic                 full;
   logic                 empty;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic      l_valid, l_ge, r_valid;
      entry_type l_entry, r_entry;

      if (i == 0) begin : g_head
         assign l_valid = 1'b1;
         assign l_ge    = 1'b0;
         assign l_entry = '0;
      end else begin : g_left
         assign l_valid = cell_valid[i-1];
         assign l_ge    = cell_ge[i-1];
         assign l_entry = cell_entry[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign r_valid = 1'b0;
         assign r_entry = '0;
      end else begin : g_right
         assign r_valid = cell_valid[i+1];
         assign r_entry = cell_entry[i+1];
      end

      dpq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left_valid  (l_valid),
         .left_ge     (l_ge),
         .left_entry  (l_entry),
         .right_valid (r_valid),
         .right_entry (r_entry),
         .valid       (cell_valid[i]),
         .ge          (cell_ge[i]),
         .entry       (cell_entry[i]),
         .leaf        (cell_leaf[i])
      );

      assign leaf_bits[i] = cell_leaf[i];
   end

   dpq_or_tree #(
      .N (CAPACITY),
      .W (LEAF_W)
   ) u_tree (
      .clock  (clock),
      .leaves (leaf_bits),
      .root   (root_bits)
   );

   assign root  = root_bits;
   assign full  = (count_ff == COUNT_W'(CAPACITY));
   assign empty = (count_ff == '0);

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      wait_in      = wait_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      ctl.cmd      = CMD_HOLD;
      ctl.client   = req_ff.client;
      ctl.key      = req_ff.priority_req;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               wait_in  = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // Wait until the tree result, through its LEVELS registered levels, lines up with the cells.
            if (wait_ff == WAIT_W'(LEVELS - 1)) begin
               state_in = S_APPLY;
            end else begin
               wait_in = wait_ff + 1'b1;
            end
         end
         S_APPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_in.client_out = '0;
               rsp_in.status     = ST_DONE;
               state_in          = S_IDLE;
               unique case (req_ff.op)
                  OP_INSERT: begin
                     if (root.dup) begin
                        rsp_in.status = ST_DUP;
                     end else if (full) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        ctl.cmd  = CMD_INSERT;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_POP_MAX: begin
                     if (empty) begin
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        ctl.cmd           = CMD_POP_MAX;
                        count_in          = count_ff - 1'b1;
                        rsp_in.client_out = root.client;
                     end
                  end
                  OP_POP_MIN: begin
                     if (empty) begin
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        ctl.cmd           = CMD_POP_MIN;
                        count_in          = count_ff - 1'b1;
                        rsp_in.client_out = cell_entry[0].client;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         wait_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         wait_ff      <= wait_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

endmodule

// ----- rtl/dpq_checker.sv -----
// Port-level checks of the double-ended priority queue, bound to the top level.
// Depends on dpq_pkg and double_ended_priority_queue_assert.svh.
`include "double_ended_priority_queue_assert.svh"

module dpq_checker
   import dpq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   // A stalled response keeps its contents.
   `DPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "response changed while stalled")

   // Only one request is in flight, so the input closes right after an accept.
   `DPQ_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "request accepted while busy")

   // Only a completed pop carries a client id.
   `DPQ_ASSERT_SAME(a_client_zero, rsp_valid && rsp_payload.status != ST_DONE, rsp_payload.client_out == '0, "client id on a failed request")

   // A new response appears only at the end of a request's processing.
   `DPQ_ASSERT_SAME(a_rsp_after_work, $rose(rsp_valid), $past(!req_ready), "response without a request")

endmodule

bind double_ended_priority_queue dpq_checker u_dpq_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

// ----- tb/tb_double_ended_priority_queue.sv -----
// Self-checking testbench of the double-ended priority queue: directed and random requests,
// checked against a sorted-entry model that the testbench keeps itself.
// Depends on dpq_pkg and on the double_ended_priority_queue module.
module tb_double_ended_priority_queue
   import dpq_pkg::*;
();

   localparam int QUEUE_DEPTH = DEFAULT_CAPACITY;
   localparam int SETTLE_CYCLES = 20;
   localparam int MAX_REPORTS = 10;
   localparam logic signed [PRIO_W-1:0] PRIO_MAX = {1'b0, {(PRIO_W-1){1'b1}}};
   localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};
   localparam logic [CLIENT_W-1:0] CLIENT_MAX = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_payload;

   entry_type stored_entries[$];
   rsp_type awaited_rsp[$];
   int mismatch_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_request = 0;
   int hold_left = 0;

   double_ended_priority_queue #(.CAPACITY(QUEUE_DEPTH)) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The stored entries are kept in ascending signed priority order.
   function automatic rsp_type apply_request(req_type r);
      rsp_type rsp;
      entry_type e;
      int pos;
      rsp.client_out = '0;
      rsp.status = ST_DONE;
      case (r.op)
         OP_INSERT: begin
            pos = 0;
            while (pos < stored_entries.size() && stored_entries[pos].key < r.priority_req)
               pos++;
            if (pos < stored_entries.size() && stored_entries[pos].key == r.priority_req) begin
               rsp.status = ST_DUP;
            end else if (stored_entries.size() >= QUEUE_DEPTH) begin
               rsp.status = ST_FULL;
            end else begin
               e.client = r.client;
               e.key = r.priority_req;
               stored_entries.insert(pos, e);
            end
         end
         OP_POP_MAX, OP_POP_MIN: begin
            if (stored_entries.size() == 0) begin
               rsp.status = ST_EMPTY;
            end else begin
               e = (r.op == OP_POP_MAX) ? stored_entries.pop_back() : stored_entries.pop_front();
               rsp.client_out = e.client;
            end
         end
         default: ;
      endcase
      return rsp;
   endfunction

   function automatic bit has_prio(logic signed [PRIO_W-1:0] p);
      foreach (stored_entries[i])
         if (stored_entries[i].key == p) return 1'b1;
      return 1'b0;
   endfunction

   function automatic logic signed [PRIO_W-1:0] fresh_prio();
      logic signed [PRIO_W-1:0] p;
      do p = $urandom(); while (has_prio(p));
      return p;
   endfunction

   function automatic logic [CLIENT_W-1:0] rand_client();
      return CLIENT_W'($urandom());
   endfunction

   // Mixes stored priorities (duplicates), a narrow band, the extremes and full-range values.
   function automatic logic signed [PRIO_W-1:0] pick_prio();
      int sel;
      sel = $urandom_range(99);
      if (sel < 15 && stored_entries.size() > 0)
         return stored_entries[$urandom_range(stored_entries.size() - 1)].key;
      if (sel < 35) return $urandom_range(40) - 20;
      if (sel < 45) begin
         case ($urandom_range(5))
            0: return PRIO_MAX;
            1: return PRIO_MIN;
            2: return PRIO_MAX - 1;
            3: return PRIO_MIN + 1;
            4: return '0;
            default: return '1;
         endcase
      end
      return $urandom();
   endfunction

   function automatic req_type make_req(op_type op, logic [CLIENT_W-1:0] client,
                                        logic signed [PRIO_W-1:0] prio);
      req_type r;
      r.op = op;
      r.client = client;
      r.priority_req = prio;
      return r;
   endfunction

   task automatic send_request(req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      awaited_rsp.push_back(apply_request(r));
   endtask

   task automatic random_request(int insert_pct);
      int sel;
      op_type op;
      sel = $urandom_range(99);
      if (sel < insert_pct) begin
         op = OP_INSERT;
      end else begin
         sel = $urandom_range(99);
         op = (sel < 4) ? OP_NONE : (sel < 52) ? OP_POP_MAX : OP_POP_MIN;
      end
      send_request(make_req(op, rand_client(), pick_prio()));
   endtask

   // The sender stays quiet until every expected response has come back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_directed();
      send_request(make_req(OP_POP_MAX, CLIENT_MAX, PRIO_MAX));
      send_request(make_req(OP_POP_MIN, '0, PRIO_MIN));
      send_request(make_req(OP_NONE, CLIENT_MAX, PRIO_MAX));
      send_request(make_req(OP_INSERT, CLIENT_MAX, PRIO_MAX));
      send_request(make_req(OP_INSERT, '0, PRIO_MIN));
      send_request(make_req(OP_INSERT, 20'h55555, '0));
      send_request(make_req(OP_INSERT, 20'hAAAAA, '1));
      send_request(make_req(OP_INSERT, 20'h12345, 32'sh55555555));
      send_request(make_req(OP_INSERT, 20'h6789A, 32'shAAAAAAAA));
      send_request(make_req(OP_INSERT, 20'h00001, PRIO_MAX));
      send_request(make_req(OP_INSERT, 20'h00002, PRIO_MIN));
      send_request(make_req(OP_INSERT, 20'h00003, '0));
      send_request(make_req(OP_NONE, rand_client(), $urandom()));
      // Pops ignore the client and priority fields.
      send_request(make_req(OP_POP_MAX, CLIENT_MAX, PRIO_MIN));
      send_request(make_req(OP_POP_MIN, CLIENT_MAX, PRIO_MAX));
      send_request(make_req(OP_POP_MAX, rand_client(), $urandom()));
      send_request(make_req(OP_POP_MIN, rand_client(), $urandom()));
      send_request(make_req(OP_POP_MAX, '0, '0));
      send_request(make_req(OP_POP_MIN, '0, '0));
      send_request(make_req(OP_POP_MAX, '0, '0));
      send_request(make_req(OP_POP_MIN, '0, '0));
      wait_for_drain();
   endtask

   task automatic test_random_traffic(int count, int insert_pct);
      repeat (count) random_request(insert_pct);
      wait_for_drain();
   endtask

   task automatic test_fill_to_full();
      logic signed [PRIO_W-1:0] p;
      while (stored_entries.size() < QUEUE_DEPTH)
         send_request(make_req(OP_INSERT, rand_client(), fresh_prio()));
      send_request(make_req(OP_INSERT, rand_client(), fresh_prio()));
      p = stored_entries[$urandom_range(QUEUE_DEPTH - 1)].key;
      // A duplicate reports as such even when the store is full.
      send_request(make_req(OP_INSERT, rand_client(), p));
      send_request(make_req(OP_NONE, rand_client(), $urandom()));
      send_request(make_req(OP_POP_MAX, rand_client(), $urandom()));
      send_request(make_req(OP_INSERT, rand_client(), fresh_prio()));
      send_request(make_req(OP_INSERT, rand_client(), fresh_prio()));
      send_request(make_req(OP_POP_MIN, rand_client(), $urandom()));
      send_request(make_req(OP_INSERT, CLIENT_MAX, fresh_prio()));
      send_request(make_req(OP_INSERT, '0, fresh_prio()));
      wait_for_drain();
   endtask

   // The receiver holds off long enough that the block stalls its input.
   task automatic test_receiver_hold();
      hold_request = 150;
      repeat (12) random_request(60);
      wait_for_drain();
   endtask

   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("Response with none expected: client_out %h status %0d",
                        rsp_payload.client_out, rsp_payload.status);
         end else begin
            rsp_type exp;
            exp = awaited_rsp.pop_front();
            if (rsp_payload.client_out !== exp.client_out ||
                rsp_payload.status !== exp.status) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("Response differs: expected client_out %h status %0d, got %h %0d",
                           exp.client_out, exp.status, rsp_payload.client_out,
                           rsp_payload.status);
            end
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 8;
      recv_idle_pct = 60;
      test_directed();
      test_random_traffic(200, 55);
      send_idle_pct = 60;
      recv_idle_pct = 8;
      test_random_traffic(200, 45);
      test_fill_to_full();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_receiver_hold();
      test_random_traffic(250, 35);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/dpq_pkg.sv
rtl/dpq_cell.sv
rtl/dpq_or_tree.sv
rtl/double_ended_priority_queue.sv
rtl/dpq_checker.sv
tb/tb_double_ended_priority_queue.sv
